FILE: rtl/core/stereo_imu_frame_deframer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo IMU frame deframer
// Concurrent checks that disappear in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef STEREO_IMU_FRAME_DEFRAMER_MACROS_SVH
`define STEREO_IMU_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SIFD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");
// next-cycle implication
`define SIFD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");
`else
`define SIFD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SIFD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/sifd_pkg.sv
// ----------------------------------------------------------------------------
// sifd_pkg
// Shared types and constants of the stereo IMU frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sifd_pkg;

  localparam int WIN_LEN    = 16;
  localparam int TDATA_W    = 104;

  localparam logic [7:0] HDR_B0     = 8'h33;
  localparam logic [7:0] HDR_B1     = 8'hCC;
  localparam logic [7:0] HDR_B14    = 8'h22;
  localparam logic [7:0] HDR_B15    = 8'hDD;
  localparam logic [7:0] IMU_MARK0  = 8'h66;
  localparam logic [7:0] IMU_MARK1  = 8'hDD;
  localparam logic [7:0] TRAIL_B0   = 8'h44;
  localparam logic [7:0] TRAIL_B1   = 8'hBB;
  localparam logic [7:0] ISB_RESET  = 8'd16;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_IMU      = 3'd1,
    KIND_TRAIL_OK = 3'd2,
    KIND_LEFT     = 3'd3,
    KIND_RIGHT    = 3'd4,
    KIND_ERROR    = 3'd5
  } kind_t;

  typedef enum logic [7:0] {
    PH_HUNT  = 8'b0000_0001,
    PH_M66   = 8'b0000_0010,
    PH_MDD   = 8'b0000_0100,
    PH_IMU   = 8'b0000_1000,
    PH_T44   = 8'b0001_0000,
    PH_TBB   = 8'b0010_0000,
    PH_LEFT  = 8'b0100_0000,
    PH_RIGHT = 8'b1000_0000
  } phase_t;

  // One result record, as handed from the parser to the output side.
  typedef struct packed {
    kind_t       kind;
    logic        last;
    logic [7:0]  data_byte;
    logic [15:0] exposure_time;
    logic [7:0]  image_count;
    logic [7:0]  imu_sample_count;
    logic [15:0] frame_height;
    logic [15:0] frame_width;
    logic [31:0] time_stamp;
  } rec_t;

endpackage

FILE: rtl/core/sifd_front.sv
// ----------------------------------------------------------------------------
// sifd_front
// Byte parser: header hunt window, frame phase sequencer and byte counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stereo_imu_frame_deframer_macros.svh"

module sifd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               accept,
  input  logic [7:0]         byte_in,
  output logic               push,
  output sifd_pkg::rec_t     push_rec
);
  import sifd_pkg::*;

  logic [WIN_LEN-1:0][7:0] win;
  logic [WIN_LEN-1:0][7:0] win_next;
  logic [WIN_LEN-1:0][7:0] shifted;
  phase_t      phase;
  phase_t      phase_next;
  logic [31:0] byte_counter;
  logic [31:0] byte_counter_next;
  logic [31:0] count_inc;
  logic [15:0] imu_length;
  logic [31:0] image_size;
  logic [15:0] height_q;
  logic [15:0] width_q;
  logic [7:0]  isb;
  logic        hdr_hit;
  logic        hdr_load;

  // Window after shifting in the current byte: entry 0 is the oldest.
  assign shifted = {byte_in, win[WIN_LEN-1:1]};
  assign hdr_hit = (phase == PH_HUNT) &&
                   (shifted[0] == HDR_B0) && (shifted[1] == HDR_B1) &&
                   (shifted[WIN_LEN-2] == HDR_B14) && (shifted[WIN_LEN-1] == HDR_B15);
  assign count_inc = byte_counter + 32'd1;

  always_comb begin
    win_next          = win;
    phase_next        = phase;
    byte_counter_next = byte_counter;
    hdr_load          = 1'b0;
    push              = 1'b0;
    push_rec          = '0;
    push_rec.kind     = KIND_ERROR;
    push_rec.last     = 1'b1;
    if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (hdr_hit) begin
            win_next                  = '0;
            hdr_load                  = 1'b1;
            byte_counter_next         = '0;
            phase_next                = PH_M66;
            push                      = 1'b1;
            push_rec.kind             = KIND_HEADER;
            push_rec.last             = 1'b0;
            push_rec.exposure_time    = {shifted[2], shifted[3]};
            push_rec.image_count      = shifted[4];
            push_rec.imu_sample_count = shifted[5];
            push_rec.frame_height     = {shifted[6], shifted[7]};
            push_rec.frame_width      = {shifted[8], shifted[9]};
            push_rec.time_stamp       = {shifted[10], shifted[11], shifted[12], shifted[13]};
          end else begin
            win_next = shifted;
          end
        end
        PH_M66, PH_T44: begin
          if (byte_in != ((phase == PH_M66) ? IMU_MARK0 : TRAIL_B0)) begin
            push = 1'b1;
          end else begin
            phase_next = (phase == PH_M66) ? PH_MDD : PH_TBB;
          end
        end
        PH_MDD: begin
          if (byte_in != IMU_MARK1) begin
            push = 1'b1;
          end else begin
            byte_counter_next = '0;
            phase_next        = (imu_length == '0) ? PH_T44 : PH_IMU;
          end
        end
        PH_IMU: begin
          push               = 1'b1;
          push_rec.kind      = KIND_IMU;
          push_rec.last      = 1'b0;
          push_rec.data_byte = byte_in;
          if (count_inc >= {16'd0, imu_length}) begin
            byte_counter_next = '0;
            phase_next        = PH_T44;
          end else begin
            byte_counter_next = count_inc;
          end
        end
        PH_TBB: begin
          push = 1'b1;
          if (byte_in == TRAIL_B1) begin
            byte_counter_next = '0;
            push_rec.kind     = KIND_TRAIL_OK;
            push_rec.last     = (image_size == '0);
            phase_next        = (image_size == '0) ? PH_HUNT : PH_LEFT;
          end
        end
        PH_LEFT, PH_RIGHT: begin
          push               = 1'b1;
          push_rec.kind      = (phase == PH_LEFT) ? KIND_LEFT : KIND_RIGHT;
          push_rec.last      = 1'b0;
          push_rec.data_byte = byte_in;
          if (count_inc >= image_size) begin
            byte_counter_next = '0;
            phase_next        = (phase == PH_LEFT) ? PH_RIGHT : PH_HUNT;
            push_rec.last     = (phase == PH_RIGHT);
          end else begin
            byte_counter_next = count_inc;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
      // Frame error: restart hunting with only the offending byte in the window.
      if (push && push_rec.kind == KIND_ERROR) begin
        win_next                 = '0;
        win_next[WIN_LEN-1]      = byte_in;
        phase_next               = PH_HUNT;
        byte_counter_next        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win          <= '0;
      phase        <= PH_HUNT;
      byte_counter <= '0;
      isb          <= ISB_RESET;
    end else begin
      win          <= win_next;
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      if (cfg_we) begin
        isb <= cfg_wdata;
      end
    end
  end

  // Header sizes: IMU length at header time, image size in the cycle after.
  always_ff @(posedge clk) begin
    if (hdr_load) begin
      imu_length <= {8'd0, shifted[5]} * {8'd0, isb};
      height_q   <= {shifted[6], shifted[7]};
      width_q    <= {shifted[8], shifted[9]};
    end
    image_size <= {16'd0, height_q} * {16'd0, width_q};
  end

  `SIFD_ASSERT_IMP(a_imu_count_bound, clk, rst, phase == PH_IMU, byte_counter < {16'd0, imu_length})
  `SIFD_ASSERT_NXT(a_hdr_clears_win, clk, rst, accept && hdr_hit, win == '0 && phase == PH_M66)
  `SIFD_ASSERT_IMP(a_push_needs_beat, clk, rst, push, accept)

endmodule

FILE: rtl/core/sifd_queue.sv
// ----------------------------------------------------------------------------
// sifd_queue
// Two-entry record queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stereo_imu_frame_deframer_macros.svh"

module sifd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sifd_pkg::rec_t push_rec,
  output logic           full,
  output logic           head_valid,
  output sifd_pkg::rec_t head_rec,
  input  logic           pop
);
  import sifd_pkg::*;

  rec_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `SIFD_ASSERT_IMP(a_no_overflow, clk, rst, push, count != 2'd2)
  `SIFD_ASSERT_IMP(a_no_underflow, clk, rst, pop, count != 2'd0)
  `SIFD_ASSERT_IMP(a_ptr_track, clk, rst, count == 2'd0 || count == 2'd2, wr_ptr == rd_ptr)

endmodule

FILE: rtl/core/sifd_back.sv
// ----------------------------------------------------------------------------
// sifd_back
// Output stage: drain the queue into the result register and pack the beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stereo_imu_frame_deframer_macros.svh"

module sifd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  sifd_pkg::rec_t               head_rec,
  output logic                         pop,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [sifd_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [2:0]                   m_axis_tuser,
  output logic                         m_axis_tlast
);
  import sifd_pkg::*;

  // Load whenever the register is empty or its beat is taken now.
  assign pop = head_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_axis_tdata <= {head_rec.time_stamp, head_rec.frame_width, head_rec.frame_height,
                       head_rec.imu_sample_count, head_rec.image_count,
                       head_rec.exposure_time, head_rec.data_byte};
      m_axis_tuser <= head_rec.kind;
      m_axis_tlast <= head_rec.last;
    end
  end

  `SIFD_ASSERT_IMP(a_no_data_on_marks, clk, rst, m_axis_tvalid && (m_axis_tuser == KIND_HEADER || m_axis_tuser == KIND_TRAIL_OK || m_axis_tuser == KIND_ERROR), m_axis_tdata[7:0] == 8'd0)
  `SIFD_ASSERT_IMP(a_err_is_last, clk, rst, m_axis_tvalid && m_axis_tuser == KIND_ERROR, m_axis_tlast)
  `SIFD_ASSERT_NXT(a_hold_beat, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

FILE: rtl/core/stereo_imu_frame_deframer.sv
// Path: an accepted byte is decided by the parser and written into the queue;
//   the output register loads it from the two-entry queue's head when free.
// Throughput: one byte per cycle while the queue has room; the parser decides
//   each byte combinationally; queue and output register absorb stalls.
// Reset (rst, synchronous, active high): hunt phase, empty window and queue,
//   imu_sample_bytes back to 16. No clearing pass; usable the cycle after.
// ----------------------------------------------------------------------------
// stereo_imu_frame_deframer
// Deframes a stereo camera byte stream with embedded IMU samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_imu_frame_deframer (
  input  logic                         clk,
  input  logic                         rst,
  // configuration: imu_sample_bytes
  input  logic                         cfg_we,
  input  logic [7:0]                   cfg_wdata,
  // byte stream in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] byte_in
  // results out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] data_byte, [23:8] exposure_time, [31:24] image_count,
  // [39:32] imu_sample_count, [55:40] frame_height, [71:56] frame_width,
  // [103:72] time_stamp
  output logic [sifd_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [2:0]                   m_axis_tuser,  // [2:0] kind
  output logic                         m_axis_tlast   // last
);
  import sifd_pkg::*;

  logic accept;
  logic push;
  rec_t push_rec;
  logic q_full;
  logic head_valid;
  rec_t head_rec;
  logic pop;

  // Take a beat whenever the queue has room; the parser never waits on output
  // directly, so a held result does not stall the byte stream until two more
  // results are pending.
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Front: hunt window, phase sequencer, IMU and pixel counters.
  sifd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .byte_in   (s_axis_tdata),
    .push      (push),
    .push_rec  (push_rec)
  );

  // Decouple: hold up to two decided results.
  sifd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop)
  );

  // Back: registered result beat toward the master side.
  sifd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_rec      (head_rec),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for stereo_imu_frame_deframer
// Feeds the deframer camera byte streams built from well-formed frames,
// broken frames and line noise. A bit-accurate predictor tracks the hunt
// window and frame phases and queues the expected result beats. The monitor
// checks every output beat field by field. Both stream sides idle at random,
// the receiver holds off once for a long stretch, and imu_sample_bytes is
// reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_top;
  import sifd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;

  // ways to break a frame on purpose
  typedef enum int {
    BRK_NONE,
    BRK_MARK0,
    BRK_MARK1,
    BRK_TRAIL0,
    BRK_TRAIL1
  } frame_break_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_we = 1'b0;
  logic [7:0]          cfg_wdata = 8'd0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'd0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                m_axis_tlast;

  stereo_imu_frame_deframer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stream bytes waiting to go out, and result beats the predictor expects.
  logic [7:0] byte_q[$];
  rec_t       result_q[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  tx_gap = 0;
  int  rx_wait = 0;
  int  rx_hold_cnt = 0;
  bit  hold_seen = 1'b0;
  bit  hold_req = 1'b0;
  bit  burst = 1'b0;
  logic [7:0] cur_isb = ISB_RESET;   // stimulus side view of imu_sample_bytes
  int  frame_bytes = 0;              // bytes pushed that belong to frames

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the deframer's window, phase, counters
  // and its one register.
  // --------------------------------------------------------------------------
  logic [7:0]  win [WIN_LEN];
  phase_t      ph;
  logic [31:0] pos_cnt;
  logic [15:0] imu_len;
  logic [31:0] img_size;
  logic [7:0]  isb_m;

  function automatic void window_push(input logic [7:0] b);
    for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i + 1];
    win[WIN_LEN - 1] = b;
  endfunction

  function automatic void window_clear();
    for (int i = 0; i < WIN_LEN; i++) win[i] = 8'd0;
  endfunction

  function automatic void deframer_reset();
    window_clear();
    ph = PH_HUNT;
    pos_cnt = '0;
    imu_len = '0;
    img_size = '0;
    isb_m = ISB_RESET;
  endfunction

  // Bad marker or trailer: restart the hunt with the offending byte as the
  // first byte of a fresh window.
  function automatic void frame_fault(input logic [7:0] b, output rec_t r);
    window_clear();
    window_push(b);
    ph = PH_HUNT;
    pos_cnt = '0;
    r = '0;
    r.kind = KIND_ERROR;
    r.last = 1'b1;
  endfunction

  // Advance the predictor by one stream byte; return 1 when a beat results.
  function automatic bit deframe_byte(input logic [7:0] b, output rec_t r);
    logic [15:0] rows;
    logic [15:0] cols;
    r = '0;
    case (ph)
      PH_HUNT: begin
        window_push(b);
        if (!(win[0] == HDR_B0 && win[1] == HDR_B1 &&
              win[14] == HDR_B14 && win[15] == HDR_B15)) return 1'b0;
        rows = {win[6], win[7]};
        cols = {win[8], win[9]};
        r.kind = KIND_HEADER;
        r.exposure_time = {win[2], win[3]};
        r.image_count = win[4];
        r.imu_sample_count = win[5];
        r.frame_height = rows;
        r.frame_width = cols;
        r.time_stamp = {win[10], win[11], win[12], win[13]};
        imu_len = {8'd0, win[5]} * {8'd0, isb_m};
        img_size = {16'd0, rows} * {16'd0, cols};
        pos_cnt = '0;
        window_clear();
        ph = PH_M66;
        return 1'b1;
      end
      PH_M66: begin
        if (b != IMU_MARK0) begin
          frame_fault(b, r);
          return 1'b1;
        end
        ph = PH_MDD;
        return 1'b0;
      end
      PH_MDD: begin
        if (b != IMU_MARK1) begin
          frame_fault(b, r);
          return 1'b1;
        end
        pos_cnt = '0;
        ph = (imu_len == 16'd0) ? PH_T44 : PH_IMU;
        return 1'b0;
      end
      PH_IMU: begin
        pos_cnt = pos_cnt + 1;
        if (pos_cnt >= {16'd0, imu_len}) begin
          pos_cnt = '0;
          ph = PH_T44;
        end
        r.kind = KIND_IMU;
        r.data_byte = b;
        return 1'b1;
      end
      PH_T44: begin
        if (b != TRAIL_B0) begin
          frame_fault(b, r);
          return 1'b1;
        end
        ph = PH_TBB;
        return 1'b0;
      end
      PH_TBB: begin
        if (b != TRAIL_B1) begin
          frame_fault(b, r);
          return 1'b1;
        end
        pos_cnt = '0;
        r.kind = KIND_TRAIL_OK;
        // empty image: the frame ends on the trailer beat
        if (img_size == 32'd0) begin
          ph = PH_HUNT;
          r.last = 1'b1;
        end else begin
          ph = PH_LEFT;
        end
        return 1'b1;
      end
      PH_LEFT: begin
        pos_cnt = pos_cnt + 1;
        if (pos_cnt >= img_size) begin
          pos_cnt = '0;
          ph = PH_RIGHT;
        end
        r.kind = KIND_LEFT;
        r.data_byte = b;
        return 1'b1;
      end
      default: begin
        pos_cnt = pos_cnt + 1;
        r.kind = KIND_RIGHT;
        r.data_byte = b;
        if (pos_cnt >= img_size) begin
          pos_cnt = '0;
          ph = PH_HUNT;
          r.last = 1'b1;
        end
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void report_result(input string tag, input rec_t r);
    $display("  %s: kind=%0d last=%0b byte=%02h exp=%04h seq=%02h n=%02h h=%04h w=%04h ts=%08h",
             tag, r.kind, r.last, r.data_byte, r.exposure_time, r.image_count,
             r.imu_sample_count, r.frame_height, r.frame_width, r.time_stamp);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued bytes, with a random gap drawn after each beat.
  // Hold the byte while the deframer stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap = 0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        s_axis_tdata <= byte_q.pop_front();
        s_axis_tvalid <= 1'b1;
        tx_gap = burst ? 0 : $urandom_range(0, 9);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here; start it once on request.
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_cnt <= 0;
      hold_seen <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      rx_hold_cnt <= RX_HOLD_CYCLES;
      hold_seen <= 1'b1;
    end else if (rx_hold_cnt > 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted input beat first, then check any
  // accepted output beat against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rec_t want;
    rec_t got;
    bit   produced;
    if (rst) begin
      deframer_reset();
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (cfg_we) isb_m = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        produced = deframe_byte(s_axis_tdata, want);
        if (produced) result_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_t'(m_axis_tuser);
        got.last = m_axis_tlast;
        got.data_byte = m_axis_tdata[7:0];
        got.exposure_time = m_axis_tdata[23:8];
        got.image_count = m_axis_tdata[31:24];
        got.imu_sample_count = m_axis_tdata[39:32];
        got.frame_height = m_axis_tdata[55:40];
        got.frame_width = m_axis_tdata[71:56];
        got.time_stamp = m_axis_tdata[103:72];
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result beat at cycle %0d", cycle_count);
            report_result("got", got);
          end
        end else begin
          want = result_q.pop_front();
          if (got.kind !== want.kind || got.last !== want.last ||
              got.data_byte !== want.data_byte ||
              got.exposure_time !== want.exposure_time ||
              got.image_count !== want.image_count ||
              got.imu_sample_count !== want.imu_sample_count ||
              got.frame_height !== want.frame_height ||
              got.frame_width !== want.frame_width ||
              got.time_stamp !== want.time_stamp) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch at cycle %0d", cycle_count);
              report_result("expected", want);
              report_result("got", got);
            end
          end
        end
        rx_wait = burst ? 0 : $urandom_range(0, 9);
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
      end
      m_axis_tready <= (rx_wait == 0) && (rx_hold_cnt == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stereo_imu_frame_deframer regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back(b);
    frame_bytes++;
  endtask

  function automatic logic [7:0] wrong_byte(input logic [7:0] good);
    logic [7:0] b;
    // now and then make the offending byte open a new header
    if ($urandom_range(0, 3) == 0) return HDR_B0;
    b = 8'($urandom);
    while (b == good) b = 8'($urandom);
    return b;
  endfunction

  task automatic push_header(input logic [15:0] expo, input logic [7:0] seq,
                             input logic [7:0] nsamp, input logic [15:0] rows,
                             input logic [15:0] cols, input logic [31:0] stamp,
                             input bit skip_first);
    if (!skip_first) push_byte(HDR_B0);
    push_byte(HDR_B1);
    push_byte(expo[15:8]);
    push_byte(expo[7:0]);
    push_byte(seq);
    push_byte(nsamp);
    push_byte(rows[15:8]);
    push_byte(rows[7:0]);
    push_byte(cols[15:8]);
    push_byte(cols[7:0]);
    push_byte(stamp[31:24]);
    push_byte(stamp[23:16]);
    push_byte(stamp[15:8]);
    push_byte(stamp[7:0]);
    push_byte(HDR_B14);
    push_byte(HDR_B15);
  endtask

  // Marker, IMU block, trailer and both images; stop early on a break.
  task automatic push_frame_body(input logic [7:0] nsamp, input logic [15:0] rows,
                                 input logic [15:0] cols, input frame_break_t brk);
    int n;
    if (brk == BRK_MARK0) begin
      push_byte(wrong_byte(IMU_MARK0));
      return;
    end
    push_byte(IMU_MARK0);
    if (brk == BRK_MARK1) begin
      push_byte(wrong_byte(IMU_MARK1));
      return;
    end
    push_byte(IMU_MARK1);
    n = int'(nsamp) * int'(cur_isb);
    for (int i = 0; i < n; i++) push_byte(8'($urandom));
    if (brk == BRK_TRAIL0) begin
      push_byte(wrong_byte(TRAIL_B0));
      return;
    end
    push_byte(TRAIL_B0);
    if (brk == BRK_TRAIL1) begin
      push_byte(wrong_byte(TRAIL_B1));
      return;
    end
    push_byte(TRAIL_B1);
    n = 2 * int'(rows) * int'(cols);
    for (int i = 0; i < n; i++) push_byte(8'($urandom));
  endtask

  task automatic push_frame(input logic [15:0] expo, input logic [7:0] seq,
                            input logic [7:0] nsamp, input logic [15:0] rows,
                            input logic [15:0] cols, input logic [31:0] stamp,
                            input frame_break_t brk);
    push_header(expo, seq, nsamp, rows, cols, stamp, 1'b0);
    push_frame_body(nsamp, rows, cols, brk);
  endtask

  // Mostly random well-formed frames, some broken ones, some line noise.
  task automatic push_random(input int budget);
    int start;
    int sel;
    int n;
    logic [7:0] nsamp;
    logic [15:0] rows;
    logic [15:0] cols;
    frame_break_t brk;
    start = frame_bytes;
    while (frame_bytes - start < budget) begin
      if ($urandom_range(0, 9) < 2) begin
        // noise the hunt just slides over, sometimes a header fragment
        if ($urandom_range(0, 1) == 1) begin
          byte_q.push_back(HDR_B0);
          byte_q.push_back(HDR_B1);
        end
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) byte_q.push_back(8'($urandom));
      end else begin
        nsamp = (cur_isb > 8'd32) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 3));
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          rows = 16'd0;
          cols = 16'($urandom);
        end else if (sel == 1) begin
          rows = 16'($urandom);
          cols = 16'd0;
        end else begin
          rows = 16'($urandom_range(0, 3));
          cols = 16'($urandom_range(0, 4));
        end
        brk = ($urandom_range(0, 9) < 8) ? BRK_NONE : frame_break_t'($urandom_range(1, 4));
        push_frame(16'($urandom), 8'($urandom), nsamp, rows, cols, $urandom, brk);
      end
    end
  endtask

  task automatic write_sample_bytes(input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_isb = v;
  endtask

  // Wait for the stream to go quiet and every expected beat to arrive, then
  // let the pipeline settle past a byte that yields no result.
  task automatic drain();
    while (byte_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, register at its reset value.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_frame(16'hFFFF, 8'hFF, 8'd1, 16'd1, 16'd2, 32'hFFFF_FFFF, BRK_NONE);
    // zero IMU length and zero image size, widest width
    push_frame(16'h0000, 8'h00, 8'd0, 16'd0, 16'hFFFF, 32'h0000_0000, BRK_NONE);
    push_frame(16'h1234, 8'h01, 8'd0, 16'hFFFF, 16'd0, 32'h8000_0001, BRK_NONE);
    // bad first marker byte that itself opens the next header
    push_header(16'hA5A5, 8'h02, 8'd0, 16'd1, 16'd1, 32'h0102_0304, 1'b0);
    push_byte(HDR_B0);
    push_header(16'h0007, 8'h03, 8'd0, 16'd0, 16'd0, 32'h0A0B_0C0D, 1'b1);
    push_frame_body(8'd0, 16'd0, 16'd0, BRK_NONE);
    push_frame(16'h5A5A, 8'h04, 8'd1, 16'd1, 16'd1, 32'h1111_2222, BRK_MARK1);
    // IMU bytes already out, then a bad trailer
    push_frame(16'h0F0F, 8'h05, 8'd1, 16'd1, 16'd1, 32'h3333_4444, BRK_TRAIL0);
    push_frame(16'hF0F0, 8'h06, 8'd0, 16'd2, 16'd1, 32'h5555_6666, BRK_TRAIL1);
    push_frame(16'h00FF, 8'h07, 8'd2, 16'd2, 16'd3, 32'h7777_8888, BRK_MARK0);
    push_frame(16'hFF00, 8'h08, 8'd2, 16'd2, 16'd3, 32'h9999_AAAA, BRK_NONE);
    drain();

    // Smallest sample size, largest sample count.
    write_sample_bytes(8'd1);
    push_frame(16'hC3C3, 8'h09, 8'hFF, 16'd1, 16'd1, 32'hDEAD_0001, BRK_NONE);
    push_random(150);
    drain();

    // Largest sample size, no receiver idling, one long hold-off.
    write_sample_bytes(8'd255);
    burst <= 1'b1;
    hold_req <= 1'b1;
    push_frame(16'h3C3C, 8'h0A, 8'd1, 16'd1, 16'd2, 32'hDEAD_0002, BRK_NONE);
    push_random(100);
    drain();
    burst <= 1'b0;

    write_sample_bytes(8'($urandom_range(2, 12)));
    push_random(250);
    drain();

    write_sample_bytes(8'($urandom_range(1, 255)));
    push_random(150);
    drain();

    if (fail_count == 0) begin
      $display("stereo_imu_frame_deframer regression: pass");
    end else begin
      $display("stereo_imu_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule
